// ----- design/engine_crank_retry_controller_macros.svh -----
// Assertion macros for the engine crank retry controller.
`ifndef ENGINE_CRANK_RETRY_CONTROLLER_MACROS_SVH
`define ENGINE_CRANK_RETRY_CONTROLLER_MACROS_SVH

`ifndef SYNTH

// Condition at this edge implies consequence at the same edge.
`define ECRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecrc assertion failed");

// Condition at this edge implies consequence at the next edge.
`define ECRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecrc assertion failed");

`else

`define ECRC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ECRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/ecrc_pkg.sv -----
// Shared types, constants and helpers of the engine crank retry controller.
package ecrc_pkg;

    localparam int MS_W       = 18;
    localparam int CNT_W      = 8;
    localparam int SEC_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [MS_W-1:0]  ELAPSED_MAX   = 18'h3FFFF;
    localparam logic [MS_W-1:0]  PAUSE_MS      = 18'd1000;
    localparam logic [MS_W-1:0]  MS_PER_SEC    = 18'd1000;
    localparam logic [MS_W-1:0]  MAX_MS_RST    = 18'd10000;
    localparam logic [MS_W-1:0]  SETTLE_MS_RST = 18'd5000;
    localparam logic [CNT_W-1:0] RETRY_RST     = 8'd1;

    // Sequence phases
    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_CRANK  = 2'd1;
    localparam logic [1:0] PH_SETTLE = 2'd2;
    localparam logic [1:0] PH_PAUSE  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_SUCCESS = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;
    localparam logic [1:0] ST_IDLE    = 2'd3;

    // Item operations
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CRANK_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CRANK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_COUNT = 3'd4;

    typedef struct packed {
        logic             crank_mode;
        logic [MS_W-1:0]  step_time_ms;
        logic [MS_W-1:0]  max_ms;
        logic [MS_W-1:0]  settle_ms;
        logic [CNT_W-1:0] retry_count;
    } ecrc_cfg_t;

    typedef struct packed {
        logic             relay_drive;
        logic [1:0]       status;
        logic [CNT_W-1:0] attempts_remaining;
    } ecrc_res_t;

    function automatic logic [MS_W-1:0] sec_to_ms(input logic [SEC_W-1:0] sec);
        return MS_W'(sec) * MS_PER_SEC;
    endfunction

endpackage

// ----- design/ecrc_if.sv -----
// Channel interfaces: input items, result items and configuration writes.
interface ecrc_item_if;
    logic valid;
    logic ready;
    logic op;
    logic engine_running;
    logic stop_input;

    modport source (output valid, op, engine_running, stop_input, input ready);
    modport sink   (input valid, op, engine_running, stop_input, output ready);
endinterface

interface ecrc_result_if;
    import ecrc_pkg::*;
    logic             valid;
    logic             ready;
    logic             relay_drive;
    logic [1:0]       status;
    logic [CNT_W-1:0] attempts_remaining;

    modport source (output valid, relay_drive, status, attempts_remaining, input ready);
    modport sink   (input valid, relay_drive, status, attempts_remaining, output ready);
endinterface

interface ecrc_cfg_if;
    import ecrc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/ecrc_cfg.sv -----
// Configuration register file with millisecond limits derived on write.
module ecrc_cfg (
    input  logic               clk,
    input  logic               rst_n,
    ecrc_cfg_if.sink           cfg,
    output ecrc_pkg::ecrc_cfg_t cfg_out
);
    import ecrc_pkg::*;

    ecrc_cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crank_mode   <= 1'b0;
            cfg_reg.step_time_ms <= '0;
            cfg_reg.max_ms       <= MAX_MS_RST;
            cfg_reg.settle_ms    <= SETTLE_MS_RST;
            cfg_reg.retry_count  <= RETRY_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CRANK_MODE:  cfg_reg.crank_mode   <= cfg.data[0];
                REG_STEP_TIME:   cfg_reg.step_time_ms <= cfg.data[MS_W-1:0];
                REG_MAX_CRANK:   cfg_reg.max_ms       <= sec_to_ms(cfg.data[SEC_W-1:0]);
                REG_SETTLE:      cfg_reg.settle_ms    <= sec_to_ms(cfg.data[SEC_W-1:0]);
                REG_RETRY_COUNT: cfg_reg.retry_count  <= cfg.data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

endmodule

// ----- design/ecrc_step.sv -----
// Sequence state and the per-item update of phase, timer and attempt count.
module ecrc_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                op,
    input  logic                running,
    input  logic                stop_in,
    input  ecrc_pkg::ecrc_cfg_t cfg,
    output ecrc_pkg::ecrc_res_t res
);
    import ecrc_pkg::*;

    logic             active_reg,   active_next;
    logic [1:0]       phase_reg,    phase_next;
    logic [MS_W-1:0]  elapsed_reg,  elapsed_next;
    logic [CNT_W-1:0] attempts_reg, attempts_next;
    logic             relay_reg,    relay_next;

    logic [MS_W-1:0]  attempt_ms;
    logic [MS_W-1:0]  elapsed_inc;
    logic [1:0]       status;

    // Timed mode may shorten the crank below the maximum
    assign attempt_ms = (!cfg.crank_mode && (cfg.step_time_ms != '0)
                         && (cfg.step_time_ms < cfg.max_ms)) ? cfg.step_time_ms : cfg.max_ms;

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        active_next   = active_reg;
        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        attempts_next = attempts_reg;
        relay_next    = relay_reg;
        status        = ST_BUSY;

        if (op == OP_START)
        begin
            attempts_next = (cfg.retry_count == '0) ? CNT_W'(1) : cfg.retry_count;
            active_next   = 1'b1;
            relay_next    = 1'b1;
            phase_next    = PH_CRANK;
            elapsed_next  = '0;
        end
        else if (!active_reg)
        begin
            status = ST_IDLE;
        end
        else
        begin
            elapsed_next = elapsed_inc;
            unique case (phase_reg)
                PH_CRANK:
                begin
                    if ((cfg.crank_mode && stop_in) || (elapsed_inc >= attempt_ms))
                    begin
                        relay_next   = 1'b0;
                        phase_next   = PH_SETTLE;
                        elapsed_next = '0;
                    end
                end
                PH_SETTLE:
                begin
                    if (elapsed_inc >= cfg.settle_ms)
                    begin
                        if (running)
                        begin
                            active_next   = 1'b0;
                            phase_next    = PH_START;
                            attempts_next = '0;
                            status        = ST_SUCCESS;
                        end
                        else if (attempts_reg > CNT_W'(1))
                        begin
                            attempts_next = attempts_reg - 1'b1;
                            phase_next    = PH_PAUSE;
                            elapsed_next  = '0;
                        end
                        else
                        begin
                            active_next   = 1'b0;
                            phase_next    = PH_START;
                            attempts_next = '0;
                            status        = ST_FAIL;
                        end
                    end
                end
                PH_PAUSE:
                begin
                    if (elapsed_inc >= PAUSE_MS)
                    begin
                        relay_next   = 1'b1;
                        phase_next   = PH_CRANK;
                        elapsed_next = '0;
                    end
                end
                default:
                begin
                    relay_next   = 1'b1;
                    phase_next   = PH_CRANK;
                    elapsed_next = '0;
                end
            endcase
        end
    end

    assign res.relay_drive        = relay_next;
    assign res.status             = status;
    assign res.attempts_remaining = attempts_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            phase_reg    <= PH_START;
            elapsed_reg  <= '0;
            attempts_reg <= '0;
            relay_reg    <= 1'b0;
        end
        else if (advance)
        begin
            active_reg   <= active_next;
            phase_reg    <= phase_next;
            elapsed_reg  <= elapsed_next;
            attempts_reg <= attempts_next;
            relay_reg    <= relay_next;
        end
    end

endmodule

// ----- design/engine_crank_retry_controller.sv -----
// Top level of the engine crank retry controller.
//
// Channels: "item" carries one input item per handshake (op: 0 a 1 ms tick,
// 1 start a crank sequence, plus engine_running and stop_input levels);
// "result" returns exactly one item per input item with the relay level,
// status (busy, succeeded, failed, idle) and attempts still left; "cfg"
// writes one of five registers by index and is always ready.
// Flow: an accepted item lands in the input register, its update is
// worked out from that register and the sequence state in one pass, and its
// result is written to the output register once that register is free,
// which raises result valid.
// Throughput is one item per clock while the receiver keeps result ready
// high.
// Reset: the sequence goes idle with the relay off and no attempts left;
// registers return to timed mode, 10 s maximum crank, 5 s settle, 1 retry.
// Stall: while the receiver holds off, the result register keeps its item
// and the input register can still take one more item; ready drops only
// when both are full.
module engine_crank_retry_controller (
    input  logic          clk,
    input  logic          rst_n,
    ecrc_item_if.sink     item,
    ecrc_result_if.source result,
    ecrc_cfg_if.sink      cfg
);
    import ecrc_pkg::*;
    `include "engine_crank_retry_controller_macros.svh"

    // Input register
    logic      s1_valid_reg;
    logic      s1_op_reg;
    logic      s1_running_reg;
    logic      s1_stop_reg;

    // Output register
    logic      out_valid_reg;
    ecrc_res_t out_res_reg;

    ecrc_cfg_t cfg_val;
    ecrc_res_t step_res;
    logic      out_free;
    logic      advance;

    // Checker terms
    logic      out_done;
    logic      out_clean;
    logic      start_adv;
    logic      out_start_ok;

    ecrc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    ecrc_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .op      (s1_op_reg),
        .running (s1_running_reg),
        .stop_in (s1_stop_reg),
        .cfg     (cfg_val),
        .res     (step_res)
    );

    // Advance when the output register is empty or being drained this cycle
    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = s1_valid_reg && out_free;
    assign item.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    // Capture the payload only on acceptance
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_op_reg      <= item.op;
            s1_running_reg <= item.engine_running;
            s1_stop_reg    <= item.stop_input;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.relay_drive        = out_res_reg.relay_drive;
    assign result.status             = out_res_reg.status;
    assign result.attempts_remaining = out_res_reg.attempts_remaining;

    assign out_done     = out_valid_reg && ((out_res_reg.status == ST_SUCCESS)
                                            || (out_res_reg.status == ST_FAIL));
    assign out_clean    = !out_res_reg.relay_drive && (out_res_reg.attempts_remaining == '0);
    assign start_adv    = advance && (s1_op_reg == OP_START);
    assign out_start_ok = out_res_reg.relay_drive && (out_res_reg.status == ST_BUSY)
                          && (out_res_reg.attempts_remaining != '0);

    // A finished sequence leaves the relay off and no attempts
    `ECRC_ASSERT_IMP(a_end_clean, clk, rst_n, out_done, out_clean)
    // An item that advances shows up in the output register
    `ECRC_ASSERT_NEXT(a_adv_out, clk, rst_n, advance, out_valid_reg)
    // A held input item is not lost while the output stalls
    `ECRC_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !out_free, s1_valid_reg)
    // A start energises the relay with at least one attempt
    `ECRC_ASSERT_NEXT(a_start, clk, rst_n, start_adv, out_start_ok)

endmodule
